[sv/acfr_pkg.sv]
// Shared types and constants for the anchored CRC frame receiver.
// Holds the phase encoding, result kinds and the bytewise CRC-32 update.
// No dependencies.
package acfr_pkg;

    localparam logic [7:0]  ANCHOR_BYTE = 8'd172;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET  = 32'hFFFF_FFFF;

    // Result kinds carried on tuser
    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_EMPTY_END = 2'd1;
    localparam logic [1:0] KIND_HDR_ERROR = 2'd2;

    typedef enum logic [2:0] {
        PH_ANCHOR   = 3'd0,
        PH_LENGTH   = 3'd1,
        PH_HDR_CRC  = 3'd2,
        PH_DATA_CRC = 3'd3,
        PH_PAYLOAD  = 3'd4
    } phase_t;

    // Reflected CRC-32, one byte folded in, eight shift steps
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[sv/anchored_crc_frame_receiver_core.sv]
// Top level of the anchored CRC frame receiver: byte in, payload items out.
// Depends on acfr_pkg for the phase type, result kinds and CRC update.
//
// Usage:
//   Received bytes enter on the s_ channel, one item per byte. The block hunts
//   for the anchor byte 172, reads a little-endian length of LEN_BYTES bytes,
//   a CRC-32 of the length bytes and a CRC-32 of the payload, then streams the
//   payload bytes out on the m_ channel. m_tlast marks the final item of a
//   message; on it m_tdata[8] gives the payload CRC verdict. m_tuser gives the
//   kind: payload byte, end of an empty message, or header CRC error.
//   Of the header, only the final CRC byte can yield an item (error or end).
//   An accepted item is held in the input register, decoded against the
//   frame state when the output stage can advance, and its result is
//   registered in the output stage, which drives m_tvalid. One byte is taken
//   per cycle unless a low m_tready stalls it; the rate is set by the
//   combinational bytewise CRC update and the length counter.
//   When m_tready is low a held result stalls the decode stage; the input
//   register still takes one more item while it is empty.
//   Reset clears both stages and returns to the anchor hunt with the CRC
//   preset to all ones.
module anchored_crc_frame_receiver_core #(
    parameter int LEN_BYTES = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [8] data_crc_ok, [15:9] zero
    output logic        m_tlast,
    output logic [1:0]  m_tuser    // [1:0] kind
);

    localparam int CNT_MAX = (LEN_BYTES > 4) ? LEN_BYTES : 4;
    localparam int CNT_W   = $clog2(CNT_MAX);

    acfr_pkg::phase_t phase_reg, phase_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      msg_length_reg, msg_length_next;
    logic [31:0]      expected_crc_reg, expected_crc_next;
    logic [31:0]      crc_reg, crc_next;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg, in_byte_next;

    logic             out_valid_reg, out_valid_next;
    logic [1:0]       out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_ok_reg, out_ok_next;

    logic             advance;
    logic             fire;
    logic             len_end;
    logic             crc_end;
    logic             hdr_match;
    logic             pay_last;
    logic [31:0]      crc_upd;
    logic [31:0]      exp_merged;
    logic             res_valid;
    logic [1:0]       res_kind;
    logic [7:0]       res_byte;
    logic             res_last;
    logic             res_ok;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign len_end   = (cnt_reg == CNT_W'(LEN_BYTES - 1));
    assign crc_end   = (cnt_reg == CNT_W'(3));
    assign crc_upd   = acfr_pkg::crc_byte(crc_reg, in_byte_reg);
    assign hdr_match = ((crc_reg ^ acfr_pkg::CRC_PRESET) == exp_merged);
    assign pay_last  = (msg_length_reg == 32'd1);

    // Place the incoming CRC byte in its lane
    always_comb
    begin
        exp_merged = expected_crc_reg;
        case (cnt_reg[1:0])
            2'd0: exp_merged[7:0]   = expected_crc_reg[7:0]   | in_byte_reg;
            2'd1: exp_merged[15:8]  = expected_crc_reg[15:8]  | in_byte_reg;
            2'd2: exp_merged[23:16] = expected_crc_reg[23:16] | in_byte_reg;
            default: exp_merged[31:24] = expected_crc_reg[31:24] | in_byte_reg;
        endcase
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            unique case (phase_reg)
                acfr_pkg::PH_LENGTH:
                begin
                    if (len_end)
                        phase_next = acfr_pkg::PH_HDR_CRC;
                end
                acfr_pkg::PH_HDR_CRC:
                begin
                    if (crc_end)
                        phase_next = hdr_match ? acfr_pkg::PH_DATA_CRC : acfr_pkg::PH_ANCHOR;
                end
                acfr_pkg::PH_DATA_CRC:
                begin
                    if (crc_end)
                        phase_next = (msg_length_reg == 32'd0) ? acfr_pkg::PH_ANCHOR
                                                               : acfr_pkg::PH_PAYLOAD;
                end
                acfr_pkg::PH_PAYLOAD:
                begin
                    if (pay_last)
                        phase_next = acfr_pkg::PH_ANCHOR;
                end
                default:
                begin
                    phase_next = (in_byte_reg == acfr_pkg::ANCHOR_BYTE) ? acfr_pkg::PH_LENGTH
                                                                         : acfr_pkg::PH_ANCHOR;
                end
            endcase
        end
    end

    // Frame state update and result
    always_comb
    begin
        cnt_next          = cnt_reg;
        msg_length_next   = msg_length_reg;
        expected_crc_next = expected_crc_reg;
        crc_next          = crc_reg;
        res_valid         = 1'b0;
        res_kind          = acfr_pkg::KIND_PAYLOAD;
        res_byte          = 8'd0;
        res_last          = 1'b0;
        res_ok            = 1'b0;
        if (fire)
        begin
            unique case (phase_reg)
                acfr_pkg::PH_LENGTH:
                begin
                    crc_next = crc_upd;
                    if (cnt_reg <= CNT_W'(3))
                    begin
                        case (cnt_reg[1:0])
                            2'd0: msg_length_next[7:0]   = msg_length_reg[7:0]   | in_byte_reg;
                            2'd1: msg_length_next[15:8]  = msg_length_reg[15:8]  | in_byte_reg;
                            2'd2: msg_length_next[23:16] = msg_length_reg[23:16] | in_byte_reg;
                            default:
                                msg_length_next[31:24] = msg_length_reg[31:24] | in_byte_reg;
                        endcase
                    end
                    else if (in_byte_reg != 8'd0)
                    begin
                        // Length wider than 32 bits: saturate
                        msg_length_next = 32'hFFFF_FFFF;
                    end
                    if (len_end)
                    begin
                        cnt_next          = '0;
                        expected_crc_next = 32'd0;
                    end
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
                acfr_pkg::PH_HDR_CRC:
                begin
                    expected_crc_next = exp_merged;
                    if (crc_end)
                    begin
                        cnt_next = '0;
                        if (hdr_match)
                        begin
                            expected_crc_next = 32'd0;
                            crc_next          = acfr_pkg::CRC_PRESET;
                        end
                        else
                        begin
                            res_valid = 1'b1;
                            res_kind  = acfr_pkg::KIND_HDR_ERROR;
                            res_last  = 1'b1;
                        end
                    end
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
                acfr_pkg::PH_DATA_CRC:
                begin
                    expected_crc_next = exp_merged;
                    if (crc_end)
                    begin
                        cnt_next = '0;
                        if (msg_length_reg == 32'd0)
                        begin
                            res_valid = 1'b1;
                            res_kind  = acfr_pkg::KIND_EMPTY_END;
                            res_last  = 1'b1;
                            res_ok    = (exp_merged == 32'd0);
                        end
                    end
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
                acfr_pkg::PH_PAYLOAD:
                begin
                    // Count the remaining length down; the final byte sees one
                    crc_next        = crc_upd;
                    msg_length_next = msg_length_reg - 32'd1;
                    res_valid       = 1'b1;
                    res_kind        = acfr_pkg::KIND_PAYLOAD;
                    res_byte        = in_byte_reg;
                    res_last        = pay_last;
                    res_ok          = pay_last &&
                                      ((crc_upd ^ acfr_pkg::CRC_PRESET) == expected_crc_reg);
                end
                default:
                begin
                    cnt_next = '0;
                    if (in_byte_reg == acfr_pkg::ANCHOR_BYTE)
                    begin
                        msg_length_next   = 32'd0;
                        expected_crc_next = 32'd0;
                        crc_next          = acfr_pkg::CRC_PRESET;
                    end
                end
            endcase
        end
    end

    // Input and output stage control
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_ok_next    = out_ok_reg;
        if (advance)
        begin
            out_valid_next = fire && res_valid;
            out_kind_next  = res_kind;
            out_byte_next  = res_byte;
            out_last_next  = res_last;
            out_ok_next    = res_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= acfr_pkg::PH_ANCHOR;
            cnt_reg          <= '0;
            msg_length_reg   <= 32'd0;
            expected_crc_reg <= 32'd0;
            crc_reg          <= acfr_pkg::CRC_PRESET;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            msg_length_reg   <= msg_length_next;
            expected_crc_reg <= expected_crc_next;
            crc_reg          <= crc_next;
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_kind_reg;

endmodule

[tb/sv/anchored_crc_frame_receiver_core_tb.sv]
// Testbench for anchored_crc_frame_receiver_core: drives framed and broken byte streams
// and checks every output item against a cycle-free model of the deframer.
// Depends on acfr_pkg and the core module.
`timescale 1ns / 100ps

module anchored_crc_frame_receiver_core_tb;

    localparam int LEN_BYTES   = 4;
    localparam int ITEM_TARGET = 1050;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       last;
        logic       ok;
    } rx_result_t;

    class frame_tracker;
        rx_result_t        results_due[$];
        acfr_pkg::phase_t  ph;
        int unsigned       nbytes;
        logic [31:0]       len_rx;
        logic [31:0]       crc_rx;
        logic [31:0]       crc_run;
        int                rx_count;
        int                fails;
        int                n_payload;
        int                n_empty;
        int                n_hdr_err;
        int                n_data_bad;

        function void clear();
            ph      = acfr_pkg::PH_ANCHOR;
            nbytes  = 0;
            len_rx  = '0;
            crc_rx  = '0;
            crc_run = acfr_pkg::CRC_PRESET;
        endfunction

        // Bit-serial reflected CRC-32, least significant bit first
        static function logic [31:0] fold(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c;
            for (int i = 0; i < 8; i++)
            begin
                if (r[0] ^ b[i])
                    r = (r >> 1) ^ acfr_pkg::CRC_POLY;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        function void push(logic [1:0] k, logic [7:0] d, logic l, logic o);
            rx_result_t r;
            r.kind = k;
            r.data = d;
            r.last = l;
            r.ok   = o;
            results_due.push_back(r);
        endfunction

        // Advance the frame state by one accepted byte and queue what it yields
        function void take_byte(logic [7:0] b);
            logic lst;
            logic ok;
            rx_count++;
            case (ph)
                acfr_pkg::PH_LENGTH:
                begin
                    crc_run = fold(crc_run, b);
                    if (nbytes < 4)
                        len_rx |= {24'd0, b} << (8 * nbytes);
                    else if (b != 8'd0)
                        len_rx = '1;
                    nbytes++;
                    if (nbytes >= LEN_BYTES)
                    begin
                        crc_rx = '0;
                        ph     = acfr_pkg::PH_HDR_CRC;
                        nbytes = 0;
                    end
                end
                acfr_pkg::PH_HDR_CRC:
                begin
                    crc_rx |= {24'd0, b} << (8 * (nbytes & 3));
                    nbytes++;
                    if (nbytes >= 4)
                    begin
                        if ((crc_run ^ acfr_pkg::CRC_PRESET) != crc_rx)
                        begin
                            push(acfr_pkg::KIND_HDR_ERROR, 8'd0, 1'b1, 1'b0);
                            ph = acfr_pkg::PH_ANCHOR;
                        end
                        else
                        begin
                            crc_rx  = '0;
                            crc_run = acfr_pkg::CRC_PRESET;
                            ph      = acfr_pkg::PH_DATA_CRC;
                        end
                        nbytes = 0;
                    end
                end
                acfr_pkg::PH_DATA_CRC:
                begin
                    crc_rx |= {24'd0, b} << (8 * (nbytes & 3));
                    nbytes++;
                    if (nbytes >= 4)
                    begin
                        if (len_rx == 32'd0)
                        begin
                            push(acfr_pkg::KIND_EMPTY_END, 8'd0, 1'b1, crc_rx == 32'd0);
                            ph = acfr_pkg::PH_ANCHOR;
                        end
                        else
                            ph = acfr_pkg::PH_PAYLOAD;
                        nbytes = 0;
                    end
                end
                acfr_pkg::PH_PAYLOAD:
                begin
                    crc_run = fold(crc_run, b);
                    nbytes++;
                    lst = (nbytes >= len_rx);
                    ok  = lst && ((crc_run ^ acfr_pkg::CRC_PRESET) == crc_rx);
                    push(acfr_pkg::KIND_PAYLOAD, b, lst, ok);
                    if (lst)
                    begin
                        ph     = acfr_pkg::PH_ANCHOR;
                        nbytes = 0;
                    end
                end
                default:
                begin
                    if (b == acfr_pkg::ANCHOR_BYTE)
                    begin
                        len_rx  = '0;
                        crc_rx  = '0;
                        crc_run = acfr_pkg::CRC_PRESET;
                        ph      = acfr_pkg::PH_LENGTH;
                    end
                    else
                        ph = acfr_pkg::PH_ANCHOR;
                    nbytes = 0;
                end
            endcase
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            fails++;
        endtask

        task check_out(logic [1:0] k, logic [7:0] d, logic l, logic o);
            rx_result_t e;
            if (results_due.size() == 0)
            begin
                report($sformatf("unexpected item kind=%0d data=%02h last=%0b ok=%0b",
                                 k, d, l, o));
                return;
            end
            e = results_due.pop_front();
            if (k !== e.kind)
                report($sformatf("kind got %0d want %0d", k, e.kind));
            if (d !== e.data)
                report($sformatf("payload byte got %02h want %02h", d, e.data));
            if (l !== e.last)
                report($sformatf("last got %0b want %0b", l, e.last));
            if (o !== e.ok)
                report($sformatf("data_crc_ok got %0b want %0b", o, e.ok));
            case (e.kind)
                acfr_pkg::KIND_PAYLOAD:   n_payload++;
                acfr_pkg::KIND_EMPTY_END: n_empty++;
                default:                  n_hdr_err++;
            endcase
            if (e.last && e.kind != acfr_pkg::KIND_HDR_ERROR && !e.ok)
                n_data_bad++;
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    frame_tracker sb;
    logic [7:0]   frame_buf[$];
    logic         quiet     = 1'b0;
    logic         long_hold = 1'b0;
    int           rx_wait   = 0;
    int           cycles    = 0;
    int           frames    = 0;

    anchored_crc_frame_receiver_core #(
        .LEN_BYTES (LEN_BYTES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("anchored_crc_frame_receiver_core verification failed");
            $finish;
        end
    end

    function int draw_gap();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Receiver: check each item, then hold off for a drawn number of cycles
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                sb.check_out(m_tuser, m_tdata[7:0], m_tlast, m_tdata[8]);
                rx_wait = draw_gap();
            end
            m_tready <= !long_hold && rx_wait == 0;
            if (rx_wait > 0)
                rx_wait--;
        end
    end

    // Stall the output for a long stretch once the stream is well under way
    initial
    begin
        @(posedge clk);
        while (sb.rx_count < 400)
            @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    task send_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.take_byte(b);
    endtask

    task send_buf(input int upto);
        for (int i = 0; i < upto; i++)
            send_byte(frame_buf[i]);
    endtask

    // Anchor, length, header CRC, payload CRC, payload; corrupt a CRC bit on request
    task build_frame(input int n, input bit hdr_bad, input bit data_bad,
                     input bit anchor_first);
        logic [31:0] hcrc;
        logic [31:0] dcrc;
        logic [7:0]  lb;
        logic [7:0]  pay[$];
        frame_buf.delete();
        pay.delete();
        frame_buf.push_back(acfr_pkg::ANCHOR_BYTE);
        hcrc = acfr_pkg::CRC_PRESET;
        for (int i = 0; i < LEN_BYTES; i++)
        begin
            lb = (i < 4) ? 8'(n >> (8 * i)) : 8'd0;
            frame_buf.push_back(lb);
            hcrc = frame_tracker::fold(hcrc, lb);
        end
        hcrc = ~hcrc;
        if (hdr_bad)
            hcrc[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(hcrc[8 * i +: 8]);
        dcrc = acfr_pkg::CRC_PRESET;
        for (int i = 0; i < n; i++)
        begin
            // anchor value inside the payload is plain data
            if ((anchor_first && i == 0) || $urandom_range(0, 7) == 0)
                lb = acfr_pkg::ANCHOR_BYTE;
            else
                lb = 8'($urandom);
            pay.push_back(lb);
            dcrc = frame_tracker::fold(dcrc, lb);
        end
        dcrc = ~dcrc;
        if (data_bad)
            dcrc[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 0; i < 4; i++)
            frame_buf.push_back(dcrc[8 * i +: 8]);
        foreach (pay[i])
            frame_buf.push_back(pay[i]);
        frames++;
    endtask

    function int pick_length();
        if ($urandom_range(0, 15) == 0)
            return $urandom_range(17, 64);
        return $urandom_range(1, 16);
    endfunction

    initial
    begin
        int mode;
        int k;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        sb = new;
        sb.clear();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: noise, empty message with good CRC, one-byte anchor payload
        send_byte(8'hFF);
        build_frame(0, 1'b0, 1'b0, 1'b0);
        send_buf(frame_buf.size());
        build_frame(1, 1'b0, 1'b0, 1'b1);
        send_buf(frame_buf.size());

        k = 0;
        while (sb.rx_count < ITEM_TARGET)
        begin
            mode = (k < 6) ? k : $urandom_range(0, 9);
            k++;
            quiet <= ($urandom_range(0, 3) == 0);
            case (mode)
                0: build_frame(pick_length(), 1'b1, 1'b0, 1'b0);
                1: build_frame(pick_length(), 1'b0, 1'b1, 1'b0);
                2: build_frame(0, 1'b0, 1'b0, 1'b0);
                3: build_frame(0, 1'b0, 1'b1, 1'b0);
                4:
                begin
                    frame_buf.delete();
                    repeat ($urandom_range(1, 6))
                        frame_buf.push_back(($urandom_range(0, 3) == 0) ? acfr_pkg::ANCHOR_BYTE
                                                                         : 8'($urandom));
                end
                5: build_frame($urandom_range(1, 12), 1'b0, 1'b0, 1'b0);
                default: build_frame(pick_length(), 1'b0, 1'b0, 1'b0);
            endcase
            // cut the frame short so the next bytes land mid-frame
            if (mode == 5)
                send_buf($urandom_range(1, frame_buf.size() - 1));
            else
                send_buf(frame_buf.size());
        end
        s_tvalid <= 1'b0;

        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Covered %0d bytes in %0d frames: %0d payload items, %0d empty ends,",
                 sb.rx_count, frames, sb.n_payload, sb.n_empty);
        $display("%0d header CRC errors, %0d payload CRC failures, %0d mismatches",
                 sb.n_hdr_err, sb.n_data_bad, sb.fails);
        if (sb.fails == 0)
            $display("anchored_crc_frame_receiver_core verification clean");
        else
            $display("anchored_crc_frame_receiver_core verification failed");
        $finish;
    end

endmodule
